// File: rtl/core/rsec_pkg.sv
// Package for the Reed-Solomon error correction encoder.
// GF(256) types, field constants, cell control struct. No dependencies.
package rsec_pkg;

    localparam int CFG_W = 6;
    localparam int EC_RESET = 10;
    localparam logic [8:0] GF_POLY = 9'h11D;

    typedef logic [7:0] gf_t;

    typedef struct packed {
        logic gen_init;
        logic gen_step;
        logic rem_clear;
        logic rem_step;
        logic out_load;
        logic out_shift;
    } rsec_ctl_t;

    function automatic gf_t gf_mul(gf_t a, gf_t b);
        logic [8:0] x;
        gf_t        r;
        x = {1'b0, a};
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                r = r ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8])
            begin
                x = x ^ GF_POLY;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/core/rsec_if.sv
// Valid/ready channel interfaces for the encoder's data and check words.
// Depends on nothing.
interface rsec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       data_last;

    modport source (output valid, output data_byte, output data_last, input ready);
    modport sink (input valid, input data_byte, input data_last, output ready);
endinterface

interface rsec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ec_byte;
    logic       ec_last;

    modport source (output valid, output ec_byte, output ec_last, input ready);
    modport sink (input valid, input ec_byte, input ec_last, output ready);
endinterface

// File: rtl/core/rsec_cell.sv
// One encoder cell: a generator coefficient, a remainder byte and an output byte.
// Depends on rsec_pkg.
module rsec_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  rsec_pkg::rsec_ctl_t ctl,
    input  rsec_pkg::gf_t     fb,
    input  rsec_pkg::gf_t     root,
    input  rsec_pkg::gf_t     gen_init,
    input  rsec_pkg::gf_t     gen_prev,
    input  rsec_pkg::gf_t     rem_prev,
    input  rsec_pkg::gf_t     out_prev,
    output rsec_pkg::gf_t     gen_q,
    output rsec_pkg::gf_t     rem_q,
    output rsec_pkg::gf_t     out_q
);
    import rsec_pkg::*;

    gf_t gen_reg;
    gf_t rem_reg;
    gf_t out_reg;
    gf_t rem_new;

    assign rem_new = rem_prev ^ gf_mul(gen_reg, fb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (ctl.rem_clear || ctl.out_load)
        begin
            rem_reg <= '0;
        end
        else if (ctl.rem_step)
        begin
            rem_reg <= rem_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.gen_init)
        begin
            gen_reg <= gen_init;
        end
        else if (ctl.gen_step)
        begin
            gen_reg <= gen_prev ^ gf_mul(gen_reg, root);
        end
        if (ctl.out_load)
        begin
            out_reg <= rem_new;
        end
        else if (ctl.out_shift)
        begin
            out_reg <= out_prev;
        end
    end

    assign gen_q = gen_reg;
    assign rem_q = rem_reg;
    assign out_q = out_reg;
endmodule

// File: rtl/core/reed_solomon_ec_encoder.sv
// Top level of the GF(256) Reed-Solomon error correction encoder.
// Depends on rsec_pkg, rsec_if and rsec_cell.
//
// Systematic RS encoder over GF(256), polynomial 0x11D, generator roots a^0..a^(n-1).
// Data words enter one per cycle on din while din.ready is high; after the word marked
// last the n check words leave on dout, highest degree first, ec_last on the final one,
// while the next block may already stream in. A last word waits only if the previous
// block's check words have not yet drained. The generator is built in the cell row
// itself, one root per cycle: after reset and after each write of the count, din is held
// off through ST_INIT and ST_BUILD. Count 0 acts as 1, counts above MAX_EC as MAX_EC.
module reed_solomon_ec_encoder #(
    parameter int MAX_EC = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [rsec_pkg::CFG_W-1:0] cfg_data,
    rsec_in_if.sink                    din,
    rsec_out_if.source                 dout
);
    import rsec_pkg::*;

    localparam int NW = $clog2(MAX_EC + 1);
    localparam int IW = (MAX_EC > 1) ? $clog2(MAX_EC) : 1;
    localparam logic [NW-1:0] N_RESET = NW'((EC_RESET > MAX_EC) ? MAX_EC : EC_RESET);

    typedef enum logic [2:0] {
        ST_INIT  = 3'b001,
        ST_BUILD = 3'b010,
        ST_RUN   = 3'b100
    } st_t;

    st_t            state_reg, state_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [NW-1:0]  step_reg, step_next;
    logic [NW-1:0]  cnt_reg, cnt_next;
    gf_t            root_reg, root_next;
    logic [NW-1:0]  cfg_n;
    logic [NW-1:0]  n_m1;
    logic [IW-1:0]  top_idx;
    gf_t            fb;
    logic           load_ok;
    logic           accept;
    logic           pop;
    rsec_ctl_t      ctl;

    gf_t gen_q [MAX_EC];
    gf_t rem_q [MAX_EC];
    gf_t out_q [MAX_EC];

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_n = NW'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_EC))
        begin
            cfg_n = NW'(MAX_EC);
        end
        else
        begin
            cfg_n = NW'(cfg_data);
        end
    end

    assign n_m1    = n_reg - NW'(1);
    assign top_idx = IW'(n_m1);
    assign fb      = din.data_byte ^ rem_q[top_idx];

    assign load_ok   = (cnt_reg == '0) || ((cnt_reg == NW'(1)) && dout.ready);
    assign din.ready = (state_reg == ST_RUN) && (!din.data_last || load_ok);
    assign accept    = din.valid && din.ready;
    assign pop       = dout.valid && dout.ready;

    assign dout.valid   = (cnt_reg != '0);
    assign dout.ec_byte = out_q[top_idx];
    assign dout.ec_last = (cnt_reg == NW'(1));

    always_comb
    begin
        ctl.gen_init  = (state_reg == ST_INIT);
        ctl.gen_step  = (state_reg == ST_BUILD);
        ctl.rem_clear = cfg_we;
        ctl.rem_step  = accept;
        ctl.out_load  = accept && din.data_last;
        ctl.out_shift = pop;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        root_next  = root_reg;
        case (state_reg)
            ST_INIT:
            begin
                state_next = ST_BUILD;
                step_next  = '0;
                root_next  = 8'h01;
            end
            ST_BUILD:
            begin
                root_next = gf_mul(root_reg, 8'h02);
                step_next = step_reg + NW'(1);
                if (step_reg == n_m1)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_INIT;
            n_next     = cfg_n;
        end
    end

    always_comb
    begin
        if (ctl.out_load)
        begin
            cnt_next = n_reg;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            n_reg     <= N_RESET;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
    end

    genvar j;
    generate
        for (j = 0; j < MAX_EC; j++)
        begin : g_cell
            gf_t gen_prev;
            gf_t rem_prev;
            gf_t out_prev;

            if (j == 0)
            begin : g_head
                assign gen_prev = '0;
                assign rem_prev = '0;
                assign out_prev = '0;
            end
            else
            begin : g_link
                assign gen_prev = gen_q[j-1];
                assign rem_prev = rem_q[j-1];
                assign out_prev = out_q[j-1];
            end

            rsec_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .fb       (fb),
                .root     (root_reg),
                .gen_init ((j == 0) ? 8'h01 : 8'h00),
                .gen_prev (gen_prev),
                .rem_prev (rem_prev),
                .out_prev (out_prev),
                .gen_q    (gen_q[j]),
                .rem_q    (rem_q[j]),
                .out_q    (out_q[j])
            );
        end
    endgenerate
endmodule

// File: tb/tb_reed_solomon_ec_encoder.sv
// Testbench for reed_solomon_ec_encoder: streams data words, predicts the check words
// over GF(256) and compares each one as it leaves. Needs rsec_pkg, rsec_if and the RTL.
`timescale 1ns / 1ps

module tb;

    import rsec_pkg::*;

    localparam int MAX_EC = 32;
    localparam int SETTLE = 12;
    localparam int LIMIT = 500000;
    localparam gf_t POLY_LOW = GF_POLY[7:0];

    typedef struct {
        gf_t  ec_byte;
        logic ec_last;
    } check_word_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    rsec_in_if  din_bus ();
    rsec_out_if dout_bus ();

    reed_solomon_ec_encoder #(
        .MAX_EC(MAX_EC)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .din     (din_bus),
        .dout    (dout_bus)
    );

    gf_t         parity [MAX_EC];
    gf_t         gen_coef [MAX_EC];
    int unsigned check_len;
    check_word_t pending_checks [$];
    check_word_t expected_word;
    int          errors;
    int unsigned cycles;
    bit          idle_on;
    int          hold_off;

    function automatic gf_t gf_times(gf_t a, gf_t b);
        gf_t acc;
        gf_t x;
        acc = '0;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc ^= x;
            end
            x = x[7] ? ({x[6:0], 1'b0} ^ POLY_LOW) : {x[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic void set_check_count(logic [CFG_W-1:0] count);
        gf_t poly [MAX_EC + 1];
        gf_t root;
        check_len = (count == 0) ? 1 : ((count > MAX_EC) ? MAX_EC : count);
        foreach (poly[j])
        begin
            poly[j] = '0;
        end
        poly[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < check_len; i++)
        begin
            for (int j = i + 1; j >= 1; j--)
            begin
                poly[j] = poly[j - 1] ^ gf_times(poly[j], root);
            end
            poly[0] = gf_times(poly[0], root);
            root = gf_times(root, 8'h02);
        end
        for (int i = 0; i < MAX_EC; i++)
        begin
            gen_coef[i] = (i < check_len) ? poly[i] : 8'h00;
            parity[i] = '0;
        end
    endfunction

    function automatic void absorb_data_word(gf_t data, logic last);
        gf_t         fb;
        check_word_t w;
        fb = data ^ parity[check_len - 1];
        for (int j = check_len - 1; j >= 1; j--)
        begin
            parity[j] = parity[j - 1] ^ gf_times(gen_coef[j], fb);
        end
        parity[0] = gf_times(gen_coef[0], fb);
        if (last)
        begin
            for (int k = 0; k < check_len; k++)
            begin
                w.ec_byte = parity[check_len - 1 - k];
                w.ec_last = (k == check_len - 1);
                pending_checks.push_back(w);
            end
            for (int j = 0; j < MAX_EC; j++)
            begin
                parity[j] = '0;
            end
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout, %0d check words outstanding", $time, pending_checks.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // predictor and checker, all on the sampled edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                set_check_count(cfg_data);
            end
            if (din_bus.valid && din_bus.ready)
            begin
                absorb_data_word(din_bus.data_byte, din_bus.data_last);
            end
            if (dout_bus.valid && dout_bus.ready)
            begin
                if (pending_checks.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: expected none, actual %h last %b",
                             $time, dout_bus.ec_byte, dout_bus.ec_last);
                end
                else
                begin
                    expected_word = pending_checks.pop_front();
                    if (dout_bus.ec_byte !== expected_word.ec_byte)
                    begin
                        errors++;
                        $display("%0t ec_byte mismatch: expected %h, actual %h",
                                 $time, expected_word.ec_byte, dout_bus.ec_byte);
                    end
                    if (dout_bus.ec_last !== expected_word.ec_last)
                    begin
                        errors++;
                        $display("%0t ec_last mismatch: expected %b, actual %b",
                                 $time, expected_word.ec_last, dout_bus.ec_last);
                    end
                end
            end
        end
    end

    // receiver: random stall per word, plus a long hold-off on request
    initial
    begin
        int gap;
        dout_bus.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                dout_bus.ready <= 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            gap = idle_on ? $urandom_range(0, 11) : 0;
            if (gap > 0)
            begin
                dout_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            dout_bus.ready <= 1'b1;
            do @(posedge clk); while (!dout_bus.valid);
        end
    end

    task automatic send_word(gf_t data, logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            din_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_bus.valid <= 1'b1;
        din_bus.data_byte <= data;
        din_bus.data_last <= last;
        do @(posedge clk); while (!din_bus.ready);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        din_bus.valid <= 1'b0;
        while (pending_checks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] count);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= count;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic gf_t rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return 8'h00;
        end
        if (pick == 1)
        begin
            return 8'hFF;
        end
        return gf_t'($urandom_range(0, 255));
    endfunction

    task automatic test_default_count();
        idle_on = 1'b0;
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b1);
        wait_drain();
    endtask

    // 0 acts as 1, 63 and 33 clamp to the maximum
    task automatic test_count_extremes();
        logic [CFG_W-1:0] counts [5];
        counts = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd33};
        idle_on = 1'b1;
        foreach (counts[i])
        begin
            write_count(counts[i]);
            send_word(rand_byte(), 1'b0);
            send_word(8'hFF, 1'b1);
            wait_drain();
        end
    endtask

    // count write between data words restarts the block
    task automatic test_mid_block_write();
        idle_on = 1'b1;
        write_count(6'd10);
        send_word(8'h12, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        wait_drain();
        write_count(6'd20);
        send_word(8'hA5, 1'b0);
        send_word(8'h3C, 1'b1);
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b0;
        write_count(6'd32);
        hold_off = 300;
        for (int b = 0; b < 5; b++)
        begin
            send_word(rand_byte(), 1'b0);
            send_word(rand_byte(), 1'b0);
            send_word(rand_byte(), 1'b1);
        end
        wait_drain();
    endtask

    task automatic test_random_blocks();
        int sent;
        int len;
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_on = (phase != 2);
            write_count(CFG_W'($urandom_range(0, 63)));
            sent = 0;
            while (sent < 20)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    send_word(rand_byte(), i == len - 1);
                end
                sent += len;
            end
            wait_drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        din_bus.valid = 1'b0;
        din_bus.data_byte = '0;
        din_bus.data_last = 1'b0;
        errors = 0;
        cycles = 0;
        idle_on = 1'b0;
        hold_off = 0;
        set_check_count(CFG_W'(EC_RESET));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_count();
        test_count_extremes();
        test_mid_block_write();
        test_output_backpressure();
        test_random_blocks();

        wait_drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
